@@ rtl/prs_pkg.sv @@
`timescale 1ns / 1ps

package prs_pkg;

  localparam int unsigned LINE_W = 24;
  localparam int unsigned XL_W   = 24;
  localparam int unsigned STEP_W = 25;
  localparam int unsigned DFLT_W = 16;

  // input tdata: line_number, crossline
  localparam int unsigned IN_DATA_W  = 48;
  // output tdata: seg_line, seg_first, seg_last, seg_step, zero pad
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - LINE_W - 2 * XL_W - STEP_W;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef struct packed {
    logic signed [STEP_W-1:0] step;
    logic signed [XL_W-1:0]   last;
    logic signed [XL_W-1:0]   first;
    logic signed [LINE_W-1:0] line;
    logic                     eol;
  } seg_t;

endpackage

@@ rtl/position_run_segmenter_unit.sv @@
`timescale 1ns / 1ps

// position run segmenter
// input channel s_axis: one word per (line, crossline) position; tuser carries
// the command (add position or flush the pending segment)
// output channel m_axis: one word per stepped segment (line, first, last, step);
// tlast marks the final segment of a line
// cfg_we_i / cfg_wdata_i write the default crossline step, used when a line
// closes with a single-point segment and no step known; write only when idle
// a segment caused by an accepted word is registered and shows on m_axis in the cycle after
// throughput: one word per cycle while the receiver does not stall; the segment
// state update is a single subtract and compare, so the next word follows with no gap
// each word causes at most one segment, held in one output register; a new
// word is taken while that register is empty or being drained in the same cycle
// receiver stall: the output register holds its segment and s_axis_tready drops
// until m_axis_tready returns
// reset: no line open, default step 1, output register empty
module position_run_segmenter_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration: default_crossline_step
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  // input words
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // [23:0] line_number, [47:24] crossline
  input  logic         s_axis_tuser,   // [0] command
  // output segments
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // [23:0] seg_line, [47:24] seg_first,
                                       // [71:48] seg_last, [96:72] seg_step, zero pad
  output logic         m_axis_tlast    // end_of_line
);

  localparam int unsigned LW = prs_pkg::LINE_W;
  localparam int unsigned XW = prs_pkg::XL_W;
  localparam int unsigned SW = prs_pkg::STEP_W;
  localparam int unsigned DW = prs_pkg::DFLT_W;

  // configuration register
  logic [DW-1:0] dflt_step_q;

  // segment state
  logic                 line_open_q, line_open_d;
  logic signed [LW-1:0] cur_line_q, cur_line_d;
  logic signed [XW-1:0] run_start_q, run_start_d;
  logic signed [XW-1:0] run_end_q, run_end_d;
  logic                 step_known_q, step_known_d;
  logic signed [SW-1:0] run_step_q, run_step_d;
  logic                 emitted_q, emitted_d;
  logic signed [SW-1:0] first_step_q, first_step_d;

  // output register
  logic          out_valid_q, out_valid_d;
  prs_pkg::seg_t out_seg_q;
  prs_pkg::seg_t seg;
  logic          emit;

  logic                 in_acc;
  prs_pkg::cmd_e        cmd;
  logic signed [LW-1:0] in_line;
  logic signed [XW-1:0] in_xl;
  logic signed [SW-1:0] diff;
  logic signed [SW-1:0] close_step;

  // word taken whenever the output register can take a result
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign cmd     = prs_pkg::cmd_e'(s_axis_tuser);
  assign in_line = s_axis_tdata[LW-1:0];
  assign in_xl   = s_axis_tdata[LW+XW-1:LW];

  // crossline difference, one bit wider so it never wraps
  assign diff = {in_xl[XW-1], in_xl} - {run_end_q[XW-1], run_end_q};

  // step of a closing segment when none was seen: first segment step of the
  // line, else the configured default
  always_comb begin
    if (step_known_q) begin
      close_step = run_step_q;
    end else if (emitted_q) begin
      close_step = first_step_q;
    end else begin
      close_step = {{(SW-DW){1'b0}}, dflt_step_q};
    end
  end

  always_comb begin
    line_open_d  = line_open_q;
    cur_line_d   = cur_line_q;
    run_start_d  = run_start_q;
    run_end_d    = run_end_q;
    step_known_d = step_known_q;
    run_step_d   = run_step_q;
    emitted_d    = emitted_q;
    first_step_d = first_step_q;
    emit         = 1'b0;
    seg.line     = cur_line_q;
    seg.first    = run_start_q;
    seg.last     = run_end_q;
    seg.step     = close_step;
    seg.eol      = 1'b1;

    if (in_acc) begin
      case (cmd)
        prs_pkg::CMD_FLUSH: begin
          if (line_open_q) begin
            emit         = 1'b1;
            line_open_d  = 1'b0;
            step_known_d = 1'b0;
            emitted_d    = 1'b0;
          end
        end
        prs_pkg::CMD_ADD: begin
          if (!line_open_q || in_line != cur_line_q) begin
            // line change closes the old line; then open a fresh one
            emit         = line_open_q;
            line_open_d  = 1'b1;
            cur_line_d   = in_line;
            run_start_d  = in_xl;
            run_end_d    = in_xl;
            step_known_d = 1'b0;
            emitted_d    = 1'b0;
          end else if (diff != '0) begin
            if (!step_known_q) begin
              run_step_d   = diff;
              step_known_d = 1'b1;
            end else if (run_step_q != diff) begin
              // step break: emit current segment, open a new one here
              emit         = 1'b1;
              seg.step     = run_step_q;
              seg.eol      = 1'b0;
              if (!emitted_q) begin
                emitted_d    = 1'b1;
                first_step_d = run_step_q;
              end
              run_start_d  = in_xl;
              step_known_d = 1'b0;
            end
            run_end_d = in_xl;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_step_q  <= DW'(1);
      line_open_q  <= 1'b0;
      cur_line_q   <= '0;
      run_start_q  <= '0;
      run_end_q    <= '0;
      step_known_q <= 1'b0;
      run_step_q   <= '0;
      emitted_q    <= 1'b0;
      first_step_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dflt_step_q <= cfg_wdata_i;
      end
      line_open_q  <= line_open_d;
      cur_line_q   <= cur_line_d;
      run_start_q  <= run_start_d;
      run_end_q    <= run_end_d;
      step_known_q <= step_known_d;
      run_step_q   <= run_step_d;
      emitted_q    <= emitted_d;
      first_step_q <= first_step_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // segment payload, loaded only when a segment is produced
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_seg_q <= seg;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_seg_q.eol;
  assign m_axis_tdata  = {{prs_pkg::OUT_PAD_W{1'b0}}, out_seg_q.step, out_seg_q.last,
                          out_seg_q.first, out_seg_q.line};

  // a stalled segment must block new words so it is not overwritten
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output segment stalled");

  // a flush of an open line yields a segment marked last of its line
  a_flush_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser && line_open_q |=> m_axis_tvalid && m_axis_tlast)
    else $error("flush of open line did not emit a last segment");

  // step and segment history only exist inside an open line
  a_state_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_known_q || emitted_q) |-> line_open_q)
    else $error("segment state set with no open line");

  // a segment broken by a step change always carries a nonzero step
  a_break_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_seg_q.eol |-> out_seg_q.step != '0)
    else $error("mid-line segment with zero step");

endmodule
